FILE: sv/rgbxy_pkg.sv
// Shared constants, types and elaboration-time table builders for the sRGB to CIE xy converter.
package rgbxy_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned FRAC_MAX      = 24;
  localparam int unsigned CH_W          = 8;
  localparam int unsigned CHROMA_W      = 16;
  localparam int unsigned QUO_W         = CHROMA_W + 1;
  localparam int unsigned LIN_DEPTH     = 1 << CH_W;

  localparam logic [63:0] ONE_Q31 = 64'd1 << 31;

  typedef logic [LIN_DEPTH-1:0][FRAC_MAX-1:0] lin_table_t;

  // Matrix coefficients in millionths; rows give X, Y and Z.
  localparam logic [63:0] MAT_MILLI [0:2][0:2] = '{
    '{64'd649926, 64'd103455, 64'd197109},
    '{64'd234327, 64'd743075, 64'd22598},
    '{64'd0,      64'd53077,  64'd1035763}
  };

  function automatic logic [63:0] coef_value(int r, int c, int f);
    return ((MAT_MILLI[r][c] << f) + 64'd500000) / 64'd1000000;
  endfunction

  function automatic logic [63:0] q31_mul(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << 30)) >> 31;
  endfunction

  function automatic logic [63:0] q31_pow5(logic [63:0] r);
    logic [63:0] r2;
    r2 = q31_mul(r, r);
    return q31_mul(q31_mul(r2, r2), r);
  endfunction

  // One entry of the sRGB decoding curve: linear segment, else a 2.4 power
  // found as v^2 times the fifth root of v^2.
  function automatic logic [63:0] lin_value(int c, int f);
    logic [63:0] cc;
    logic [63:0] v;
    logic [63:0] v2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] big;
    logic [63:0] lin;
    logic [63:0] maxv;
    cc   = 64'(c);
    maxv = (64'd1 << f) - 64'd1;
    if (cc * 64'd100000 <= 64'd1031475) begin
      return (((64'd100 * cc) << f) + 64'd164730) / 64'd329460;
    end
    v = ((64'd1000 * cc + 64'd14025) << 31) / 64'd269025;
    if (v > ONE_Q31) begin
      v = ONE_Q31;
    end
    v2 = q31_mul(v, v);
    lo = 64'd0;
    hi = ONE_Q31;
    for (int i = 0; i < 40; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (q31_pow5(mid) <= v2) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    big = q31_mul(v2, lo);
    lin = (big + (64'd1 << (30 - f))) >> (31 - f);
    return (lin > maxv) ? maxv : lin;
  endfunction

  function automatic lin_table_t build_lin_table(int f);
    lin_table_t t;
    for (int c = 0; c < LIN_DEPTH; c++) begin
      t[c] = FRAC_MAX'(lin_value(c, f));
    end
    return t;
  endfunction

endpackage

FILE: sv/rgb_to_cie_xy.sv
// Top level of the sRGB pixel to CIE xy chromaticity converter.
// This block converts one 8-bit gamma-encoded sRGB pixel per clock into its CIE xy
// chromaticity in unsigned Q0.16. Each channel is decoded through a 256-entry
// constant table, a fixed 3x3 matrix gives X, Y and Z, and x = X/(X+Y+Z) and
// y = Y/(X+Y+Z) are formed by a restoring divider that retires one quotient bit
// per stage. A pixel whose X+Y+Z is zero comes out with both chromaticities zero
// and is_black set, and a ratio that rounds to one saturates to 65535. The
// pipeline takes one item every clock while the output is not stalled, and it has
// one table stage, three matrix stages, seventeen divider stages and one output
// stage; the divider's seventeen quotient bits set its depth. When the
// output is stalled the whole pipeline holds, and a one-entry skid register at
// the input still takes one more item, so in_ready is a register output.
module rgb_to_cie_xy #(
  parameter int unsigned FRAC_BITS = rgbxy_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rgbxy_pkg::CH_W-1:0]     red,
  input  logic [rgbxy_pkg::CH_W-1:0]     green,
  input  logic [rgbxy_pkg::CH_W-1:0]     blue,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rgbxy_pkg::CHROMA_W-1:0] chroma_x,
  output logic [rgbxy_pkg::CHROMA_W-1:0] chroma_y,
  output logic                           is_black
);
  import rgbxy_pkg::*;

  localparam int unsigned NW = FRAC_BITS + QUO_W + 1;
  localparam int unsigned DW = FRAC_BITS + 3;

  // The pipeline advances whenever the output register is empty or being taken.
  logic en;
  assign en = !out_valid || out_ready;

  // Skid register: holds an item accepted while the pipeline is stalled.
  logic            skid_vld;
  logic            skid_vld_next;
  logic [CH_W-1:0] skid_r;
  logic [CH_W-1:0] skid_g;
  logic [CH_W-1:0] skid_b;
  logic            accept;

  assign in_ready = !skid_vld;
  assign accept   = in_valid && in_ready;

  always_comb begin
    skid_vld_next = skid_vld;
    if (skid_vld && en) begin
      skid_vld_next = 1'b0;
    end else if (accept && !en) begin
      skid_vld_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_vld <= 1'b0;
    end else begin
      skid_vld <= skid_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !en) begin
      skid_r <= red;
      skid_g <= green;
      skid_b <= blue;
    end
  end

  // The item entering the pipeline comes from the skid register first.
  logic            pipe_vld;
  logic [CH_W-1:0] pipe_r;
  logic [CH_W-1:0] pipe_g;
  logic [CH_W-1:0] pipe_b;

  assign pipe_vld = skid_vld || accept;
  assign pipe_r   = skid_vld ? skid_r : red;
  assign pipe_g   = skid_vld ? skid_g : green;
  assign pipe_b   = skid_vld ? skid_b : blue;

  logic                 lin_vld;
  logic [FRAC_BITS-1:0] lin_r;
  logic [FRAC_BITS-1:0] lin_g;
  logic [FRAC_BITS-1:0] lin_b;

  rgbxy_lin #(.FRAC_BITS(FRAC_BITS)) u_lin (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (pipe_vld),
    .red     (pipe_r),
    .green   (pipe_g),
    .blue    (pipe_b),
    .out_vld (lin_vld),
    .lin_r   (lin_r),
    .lin_g   (lin_g),
    .lin_b   (lin_b)
  );

  logic          mtx_vld;
  logic [NW-1:0] num_x;
  logic [NW-1:0] num_y;
  logic [DW-1:0] sum;
  logic          black;

  rgbxy_mtx #(.FRAC_BITS(FRAC_BITS)) u_mtx (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (lin_vld),
    .lin_r   (lin_r),
    .lin_g   (lin_g),
    .lin_b   (lin_b),
    .out_vld (mtx_vld),
    .num_x   (num_x),
    .num_y   (num_y),
    .sum     (sum),
    .black   (black)
  );

  rgbxy_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (mtx_vld),
    .num_x    (num_x),
    .num_y    (num_y),
    .sum      (sum),
    .black    (black),
    .out_vld  (out_valid),
    .chroma_x (chroma_x),
    .chroma_y (chroma_y),
    .is_black (is_black)
  );

endmodule

FILE: sv/rgbxy_lin.sv
// Linearization stage: sRGB decoding curve looked up from a constant table.
module rgbxy_lin #(
  parameter int unsigned FRAC_BITS = rgbxy_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [rgbxy_pkg::CH_W-1:0] red,
  input  logic [rgbxy_pkg::CH_W-1:0] green,
  input  logic [rgbxy_pkg::CH_W-1:0] blue,
  output logic                      out_vld,
  output logic [FRAC_BITS-1:0]      lin_r,
  output logic [FRAC_BITS-1:0]      lin_g,
  output logic [FRAC_BITS-1:0]      lin_b
);
  import rgbxy_pkg::*;

  localparam lin_table_t LIN_TAB = build_lin_table(FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin_r <= LIN_TAB[red][FRAC_BITS-1:0];
      lin_g <= LIN_TAB[green][FRAC_BITS-1:0];
      lin_b <= LIN_TAB[blue][FRAC_BITS-1:0];
    end
  end

endmodule

FILE: sv/rgbxy_mtx.sv
// Matrix stages: products, rounded XYZ sums, then divisor and rounded numerators.
module rgbxy_mtx #(
  parameter int unsigned FRAC_BITS = rgbxy_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_vld,
  input  logic [FRAC_BITS-1:0]                    lin_r,
  input  logic [FRAC_BITS-1:0]                    lin_g,
  input  logic [FRAC_BITS-1:0]                    lin_b,
  output logic                                    out_vld,
  output logic [FRAC_BITS+rgbxy_pkg::QUO_W:0]     num_x,
  output logic [FRAC_BITS+rgbxy_pkg::QUO_W:0]     num_y,
  output logic [FRAC_BITS+2:0]                    sum,
  output logic                                    black
);
  import rgbxy_pkg::*;

  localparam int unsigned CW = FRAC_BITS + 1;
  localparam int unsigned PW = FRAC_BITS + CW;
  localparam int unsigned AW = PW + 2;
  localparam int unsigned TW = FRAC_BITS + 1;
  localparam int unsigned DW = FRAC_BITS + 3;
  localparam int unsigned NW = FRAC_BITS + QUO_W + 1;
  localparam logic [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

  logic [FRAC_BITS-1:0] lin [3];
  logic [PW-1:0]        prod [3][3];
  logic [TW-1:0]        tri_v [3];
  logic                 vld_a;
  logic                 vld_b;
  logic [DW-1:0]        sum_next;

  always_comb begin
    lin[0] = lin_r;
    lin[1] = lin_g;
    lin[2] = lin_b;
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam logic [CW-1:0] COEF = CW'(coef_value(i, j, FRAC_BITS));
      always_ff @(posedge clk) begin
        if (en) begin
          prod[i][j] <= PW'(lin[j]) * PW'(COEF);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        tri_v[i] <= TW'((AW'(prod[i][0]) + AW'(prod[i][1]) + AW'(prod[i][2]) + HALF)
                        >> FRAC_BITS);
      end
    end
  end

  assign sum_next = DW'(tri_v[0]) + DW'(tri_v[1]) + DW'(tri_v[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      num_x <= {NW'(tri_v[0]) << CHROMA_W} + NW'(sum_next >> 1);
      num_y <= {NW'(tri_v[1]) << CHROMA_W} + NW'(sum_next >> 1);
      sum   <= sum_next;
      black <= (sum_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a   <= 1'b0;
      vld_b   <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld_a   <= in_vld;
      vld_b   <= vld_a;
      out_vld <= vld_b;
    end
  end

endmodule

FILE: sv/rgbxy_div.sv
// Pipelined restoring divider, one quotient bit per stage, for x and y sharing one divisor.
module rgbxy_div #(
  parameter int unsigned FRAC_BITS = rgbxy_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic [FRAC_BITS+rgbxy_pkg::QUO_W:0] num_x,
  input  logic [FRAC_BITS+rgbxy_pkg::QUO_W:0] num_y,
  input  logic [FRAC_BITS+2:0]                sum,
  input  logic                                black,
  output logic                                out_vld,
  output logic [rgbxy_pkg::CHROMA_W-1:0]      chroma_x,
  output logic [rgbxy_pkg::CHROMA_W-1:0]      chroma_y,
  output logic                                is_black
);
  import rgbxy_pkg::*;

  localparam int unsigned NW = FRAC_BITS + QUO_W + 1;
  localparam int unsigned DW = FRAC_BITS + 3;
  localparam int unsigned EW = NW + QUO_W;

  logic [NW-1:0]    rx  [QUO_W+1];
  logic [NW-1:0]    ry  [QUO_W+1];
  logic [QUO_W-1:0] qx  [QUO_W+1];
  logic [QUO_W-1:0] qy  [QUO_W+1];
  logic [DW-1:0]    dv  [QUO_W+1];
  logic             blk [QUO_W+1];
  logic             vld [QUO_W+1];

  assign rx[0]  = num_x;
  assign ry[0]  = num_y;
  assign qx[0]  = '0;
  assign qy[0]  = '0;
  assign dv[0]  = sum;
  assign blk[0] = black;
  assign vld[0] = in_vld;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int unsigned B = QUO_W - 1 - k;
    logic [EW-1:0] dsh;
    logic          gex;
    logic          gey;
    assign dsh = EW'(dv[k]) << B;
    assign gex = (EW'(rx[k]) >= dsh);
    assign gey = (EW'(ry[k]) >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        rx[k+1]  <= gex ? NW'(EW'(rx[k]) - dsh) : rx[k];
        ry[k+1]  <= gey ? NW'(EW'(ry[k]) - dsh) : ry[k];
        qx[k+1]  <= {qx[k][QUO_W-2:0], gex};
        qy[k+1]  <= {qy[k][QUO_W-2:0], gey};
        dv[k+1]  <= dv[k];
        blk[k+1] <= blk[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  // A quotient of 65536 saturates; a black pixel forces both outputs to zero.
  always_ff @(posedge clk) begin
    if (en) begin
      is_black <= blk[QUO_W];
      if (blk[QUO_W]) begin
        chroma_x <= '0;
        chroma_y <= '0;
      end else begin
        chroma_x <= qx[QUO_W][QUO_W-1] ? '1 : qx[QUO_W][CHROMA_W-1:0];
        chroma_y <= qy[QUO_W][QUO_W-1] ? '1 : qy[QUO_W][CHROMA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[QUO_W];
    end
  end

endmodule

FILE: sv/rgbxy_chk.sv
// Port-level checker for the chromaticity converter, bound to the top level.
module rgbxy_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [rgbxy_pkg::CH_W-1:0]     red,
  input logic [rgbxy_pkg::CH_W-1:0]     green,
  input logic [rgbxy_pkg::CH_W-1:0]     blue,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [rgbxy_pkg::CHROMA_W-1:0] chroma_x,
  input logic [rgbxy_pkg::CHROMA_W-1:0] chroma_y,
  input logic                           is_black
);
  import rgbxy_pkg::*;

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chroma_x) && $stable(chroma_y)
      && $stable(is_black))
    else $error("stalled result changed");

  // A black result carries zero chromaticity.
  a_black_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_black |-> chroma_x == '0 && chroma_y == '0)
    else $error("black result with nonzero chromaticity");

  // x and y are parts of one whole, so their sum cannot exceed one by more than rounding.
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_black |->
      ((CHROMA_W+1)'(chroma_x) + (CHROMA_W+1)'(chroma_y)) <= (CHROMA_W+1)'(65537))
    else $error("x plus y exceeds one");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rgb_to_cie_xy rgbxy_chk u_rgbxy_chk (.*);

FILE: tb/tb_top.sv
// Testbench for the sRGB pixel to CIE xy chromaticity converter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FB = rgbxy_pkg::FRAC_BITS_DEF;
  localparam int unsigned RANDOM_ITEMS = 1030;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic        blk;
  } chroma_t;

  // Scoreboard: predicts the chromaticity of each accepted pixel and checks results in order.
  class chroma_board;
    chroma_t pending[$];
    int unsigned errors;
    int unsigned pixels_in;
    int unsigned results_ok;
    int unsigned blacks;
    int unsigned saturated;
    logic [63:0] decode_lut[256];
    logic [63:0] kmat[3][3];

    function logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
      return (a * b + (64'd1 << 30)) >> 31;
    endfunction

    // sRGB decode: the linear toe, or v^2.4 as v^2 times the fifth root of v^2.
    function logic [63:0] srgb_decode(int code);
      logic [63:0] c, v, v2, lo, hi, mid, p, big, lin;
      c = 64'(code);
      if (c * 64'd100000 <= 64'd1031475) begin
        return (((64'd100 * c) << FB) + 64'd164730) / 64'd329460;
      end
      v = ((64'd1000 * c + 64'd14025) << 31) / 64'd269025;
      if (v > (64'd1 << 31)) begin
        v = 64'd1 << 31;
      end
      v2 = fix_mul(v, v);
      lo = 0;
      hi = 64'd1 << 31;
      while (lo < hi) begin
        mid = lo + (hi - lo + 64'd1) / 2;
        p = fix_mul(mid, mid);
        p = fix_mul(fix_mul(p, p), mid);
        if (p <= v2) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
      big = fix_mul(v2, lo);
      lin = (big + (64'd1 << (30 - FB))) >> (31 - FB);
      return (lin > (64'd1 << FB) - 1) ? (64'd1 << FB) - 1 : lin;
    endfunction

    function new();
      logic [63:0] m[3][3];
      m = '{'{64'd649926, 64'd103455, 64'd197109},
            '{64'd234327, 64'd743075, 64'd22598},
            '{64'd0, 64'd53077, 64'd1035763}};
      for (int i = 0; i < 256; i++) decode_lut[i] = srgb_decode(i);
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++)
          kmat[r][k] = ((m[r][k] << FB) + 64'd500000) / 64'd1000000;
    endfunction

    function logic [15:0] ratio(logic [63:0] num, logic [63:0] s);
      logic [63:0] q;
      q = (num * 64'd65536 + s / 2) / s;
      if (q > 64'd65535) begin
        saturated++;
        return 16'hFFFF;
      end
      return q[15:0];
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      logic [63:0] lin[3], xyz[3], acc, s;
      chroma_t e;
      lin = '{decode_lut[r], decode_lut[g], decode_lut[b]};
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += lin[j] * kmat[i][j];
        xyz[i] = (acc + (64'd1 << (FB - 1))) >> FB;
      end
      s = xyz[0] + xyz[1] + xyz[2];
      if (s == 0) begin
        e = '{16'd0, 16'd0, 1'b1};
        blacks++;
      end else begin
        e = '{ratio(xyz[0], s), ratio(xyz[1], s), 1'b0};
      end
      pending.insert(pending.size(), e);
      pixels_in++;
    endfunction

    function void check_result(logic [15:0] cx, logic [15:0] cy, logic blk);
      chroma_t e;
      bit bad;
      if (pending.size() == 0) begin
        $error("result with no pixel pending: x=%0d y=%0d black=%0b", cx, cy, blk);
        errors++;
        return;
      end
      e = pending.pop_front();
      bad = 0;
      if (cx !== e.cx) begin
        $error("chroma_x expected %0d actual %0d", e.cx, cx);
        bad = 1;
      end
      if (cy !== e.cy) begin
        $error("chroma_y expected %0d actual %0d", e.cy, cy);
        bad = 1;
      end
      if (blk !== e.blk) begin
        $error("is_black expected %0b actual %0b", e.blk, blk);
        bad = 1;
      end
      if (bad) errors++;
      else results_ok++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] red = '0, green = '0, blue = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] chroma_x, chroma_y;
  logic is_black;

  chroma_board board;
  int unsigned cycles = 0;
  bit stim_done = 0;
  // Long receiver hold-off is requested by the sender process and counted by the receiver.
  bit hold_req = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb_to_cie_xy dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .chroma_x(chroma_x), .chroma_y(chroma_y), .is_black(is_black)
  );

  // Inputs and outputs are sampled at the clock edge, before the nonblocking updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_pixel(red, green, blue);
      if (out_valid && out_ready) board.check_result(chroma_x, chroma_y, is_black);
    end
  end

  // Present one pixel and hold it until the block accepts it.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_gap(int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Mostly random codes, with a bias toward the extremes, the toe of the curve and its knee.
  function automatic logic [7:0] pick_code();
    case ($urandom_range(9))
      0: return 8'($urandom_range(3));
      1: return 8'($urandom_range(252, 255));
      2: return 8'($urandom_range(8, 13));
      default: return 8'($urandom);
    endcase
  endfunction

  // Receiver: stalls on its own random pattern, with quiet spells of full speed and one long hold.
  initial begin
    int unsigned mode_left;
    bit eager;
    mode_left = 0;
    eager = 1;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end
      if (mode_left == 0) begin
        eager = $urandom_range(2) == 0;
        mode_left = $urandom_range(10, 120);
      end
      mode_left--;
      out_ready <= eager ? 1'b1 : ($urandom_range(3) != 0);
    end
  end

  initial begin
    logic [7:0] dir[$][3];
    int unsigned burst;
    bit hold_sent;
    hold_sent = 0;
    board = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pixels: black, near-black codes, full-scale channels, the linear toe
    // and its knee, and single primaries.
    dir = '{'{8'd0, 8'd0, 8'd0}, '{8'd1, 8'd0, 8'd0}, '{8'd0, 8'd1, 8'd0},
            '{8'd0, 8'd0, 8'd1}, '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd0},
            '{8'd0, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd255}, '{8'd10, 8'd10, 8'd10},
            '{8'd11, 8'd11, 8'd11}, '{8'd10, 8'd11, 8'd12}, '{8'd128, 8'd128, 8'd128},
            '{8'd255, 8'd255, 8'd0}, '{8'd0, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd255},
            '{8'd170, 8'd85, 8'd170}, '{8'd85, 8'd170, 8'd85}, '{8'd1, 8'd1, 8'd1},
            '{8'd2, 8'd0, 8'd0}};
    foreach (dir[i]) send_pixel(dir[i][0], dir[i][1], dir[i][2]);

    for (int n = 0; n < RANDOM_ITEMS; n += burst) begin
      burst = $urandom_range(1, 40);
      // Partway through, the receiver holds off long enough to fill the pipeline.
      if (n > 300 && !hold_sent) begin
        hold_req = 1;
        hold_sent = 1;
      end
      for (int k = 0; k < burst; k++) send_pixel(pick_code(), pick_code(), pick_code());
      idle_gap($urandom_range(3) == 0 ? 0 : $urandom_range(1, 12));
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    @(posedge stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Converted %0d pixels, %0d results matched, %0d black, %0d saturated.",
             board.pixels_in, board.results_ok, board.blacks, board.saturated);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == TIMEOUT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

FILE: sim.f
sv/rgbxy_pkg.sv
sv/rgbxy_lin.sv
sv/rgbxy_mtx.sv
sv/rgbxy_div.sv
sv/rgb_to_cie_xy.sv
sv/rgbxy_chk.sv
tb/tb_top.sv
